FILE: sv/gyi_pkg.sv
// Shared types, codes and constants for the gyro yaw integrator.
package gyi_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_CAL_SAMPLE  = 2'd0,
    OP_END_CAL     = 2'd1,
    OP_INTEGRATE   = 2'd2,
    OP_ANGLE_RESET = 2'd3
  } gyi_op_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIVIDE,
    ST_WRITE
  } gyi_state_e;

  // Divisor selection for the shared divider
  typedef enum logic [0:0] {
    DIV_CAL  = 1'b0,
    DIV_TICK = 1'b1
  } gyi_div_sel_e;

  // Field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned HEADING_W = 48;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned BIAS_W    = 24;

  // Divider geometry: numerator below 2^49
  localparam int unsigned DIV_NUM_W = 49;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  // Scaling constants and parameter defaults
  localparam int unsigned COUNTS_PER_DPS  = 131;
  localparam int unsigned CAL_SAMPLES_DEF = 100;
  localparam int unsigned TICK_RATE_DEF   = 1000;

  localparam logic [BIAS_W-1:0] BIAS_MAX = 24'h7F_FFFF;
  localparam logic [BIAS_W-1:0] BIAS_MIN = 24'h80_0000;

  // Classified command word
  typedef struct packed {
    gyi_op_e               op;
    logic [SAMPLE_W-1:0]   sample;
    logic [TICKS_W-1:0]    ticks;
  } gyi_cmd_t;

  // Divider start request
  typedef struct packed {
    logic                  start;
    gyi_div_sel_e          sel;
    logic [DIV_NUM_W-1:0]  num;
  } gyi_div_req_t;

endpackage

FILE: sv/gyi_front.sv
// Front end: accepts input words, classifies them and queues commands.
module gyi_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            opcode_i,
  input  logic signed [gyi_pkg::SAMPLE_W-1:0]   rate_sample_i,
  input  logic [gyi_pkg::TICKS_W-1:0]           elapsed_ticks_i,
  output logic                                  cmd_valid_o,
  output gyi_pkg::gyi_cmd_t                     cmd_o,
  input  logic                                  cmd_pop_i
);

  localparam int unsigned DEPTH = gyi_pkg::CMDQ_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gyi_pkg::gyi_cmd_t entry_q [DEPTH];
  gyi_pkg::gyi_cmd_t cmd_in;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  // Classify the incoming word
  always_comb begin
    cmd_in.op     = gyi_pkg::gyi_op_e'(opcode_i);
    cmd_in.sample = rate_sample_i;
    cmd_in.ticks  = elapsed_ticks_i;
  end

  assign full        = (count_q == CNT_W'(DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the queued command word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: sv/gyi_divider.sv
// Division by the two fixed divisors through a reciprocal multiplication.
module gyi_divider #(
  parameter int unsigned CAL_SAMPLES = gyi_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned TICK_RATE   = gyi_pkg::TICK_RATE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gyi_pkg::gyi_div_req_t             req_i,
  output logic                              done_o,
  output logic [gyi_pkg::DIV_NUM_W-1:0]     quot_o
);

  // Quotient is (num * M) >> S with M = ceil(2^S / den) and S = NUM_W + clog2(den),
  // which is exact for every numerator below 2^NUM_W.
  localparam int unsigned NUM_W    = gyi_pkg::DIV_NUM_W;
  localparam int unsigned M_W      = NUM_W + 1;
  localparam int unsigned LO_W     = (M_W + 1) / 2;
  localparam int unsigned ACC_W    = NUM_W + M_W;
  localparam int unsigned TICK_DEN = gyi_pkg::COUNTS_PER_DPS * TICK_RATE;
  localparam int unsigned S_CAL    = NUM_W + $clog2(CAL_SAMPLES);
  localparam int unsigned S_TICK   = NUM_W + $clog2(TICK_DEN);

  localparam logic [127:0] M_CAL_W  =
    ((128'd1 << S_CAL) + 128'(CAL_SAMPLES - 1)) / 128'(CAL_SAMPLES);
  localparam logic [127:0] M_TICK_W =
    ((128'd1 << S_TICK) + 128'(TICK_DEN - 1)) / 128'(TICK_DEN);
  localparam logic [M_W-1:0] M_CAL  = M_CAL_W[M_W-1:0];
  localparam logic [M_W-1:0] M_TICK = M_TICK_W[M_W-1:0];

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [1:0]                 step_q, step_d;
  gyi_pkg::gyi_div_sel_e      sel_q, sel_d;
  logic [NUM_W-1:0]           num_q, num_d;
  logic [ACC_W-1:0]           acc_q, acc_d;
  logic [M_W-1:0]             recip;
  logic [LO_W-1:0]            mul_a, mul_b;
  logic [2*LO_W-1:0]          part;
  logic [ACC_W-1:0]           part_sh;

  // Pick the reciprocal and the operand halves for this step
  assign recip = (sel_q == gyi_pkg::DIV_TICK) ? M_TICK : M_CAL;
  assign mul_a = step_q[1] ? LO_W'(num_q[NUM_W-1:LO_W]) : num_q[LO_W-1:0];
  assign mul_b = step_q[0] ? LO_W'(recip[M_W-1:LO_W]) : recip[LO_W-1:0];
  assign part  = mul_a * mul_b;

  // Weight the partial product by its halves
  always_comb begin
    part_sh = ACC_W'(part);
    if (step_q[0]) begin
      part_sh = part_sh << LO_W;
    end
    if (step_q[1]) begin
      part_sh = part_sh << LO_W;
    end
  end

  // Accumulate four partial products, then flag the quotient
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    sel_d  = sel_q;
    num_d  = num_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      sel_d  = req_i.sel;
      num_d  = req_i.num;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d  = acc_q + part_sh;
      step_d = step_q + 1'b1;
      if (step_q == 2'b11) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    num_q <= num_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign quot_o = (sel_q == gyi_pkg::DIV_TICK) ? NUM_W'(acc_q >> S_TICK)
                                                : NUM_W'(acc_q >> S_CAL);

endmodule

FILE: sv/gyi_back.sv
// Back end: executes commands, holds calibration and yaw state, buffers the result.
module gyi_back #(
  parameter int unsigned CAL_SAMPLES = gyi_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned TICK_RATE   = gyi_pkg::TICK_RATE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  gyi_pkg::gyi_cmd_t                     cmd_i,
  output logic                                  cmd_pop_o,
  output gyi_pkg::gyi_div_req_t                 div_req_o,
  input  logic                                  div_done_i,
  input  logic [gyi_pkg::DIV_NUM_W-1:0]         div_quot_i,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [gyi_pkg::HEADING_W-1:0]  heading_o
);

  localparam int unsigned NUM_W = gyi_pkg::DIV_NUM_W;
  localparam int unsigned YAW_W = gyi_pkg::HEADING_W;
  localparam int unsigned SUM_W = gyi_pkg::SUM_W;
  localparam int unsigned BW    = gyi_pkg::BIAS_W;
  localparam int unsigned SW    = gyi_pkg::SAMPLE_W;
  localparam int unsigned TW    = gyi_pkg::TICKS_W;
  localparam int unsigned DIFF_W = SW + 9;
  localparam int unsigned PROD_W = DIFF_W + TW + 1;

  localparam int unsigned TICK_DEN = gyi_pkg::COUNTS_PER_DPS * TICK_RATE;
  localparam logic [NUM_W-1:0] ROUND_TICK = NUM_W'(TICK_DEN / 2);
  localparam logic [NUM_W-1:0] ROUND_CAL  = NUM_W'(CAL_SAMPLES / 2);

  gyi_pkg::gyi_state_e       state_q, state_d;
  gyi_pkg::gyi_op_e          op_q, op_d;
  logic [SUM_W-1:0]          cal_sum_q, cal_sum_d;
  logic [BW-1:0]             bias_q, bias_d;
  logic [YAW_W-1:0]          yaw_q, yaw_d;
  logic [YAW_W-1:0]          ref_q, ref_d;
  logic                      neg_q, neg_d;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic [TW-1:0]             ticks_q, ticks_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic                      out_valid_q, out_valid_d;
  logic [YAW_W-1:0]          heading_q, heading_d;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W:0]            sum_mag;
  logic [PROD_W-1:0]         prod_mag;
  logic [YAW_W-1:0]          inc_mag;

  // Magnitudes for the divider operands
  assign sum_ext  = {cal_sum_q[SUM_W-1], cal_sum_q};
  assign sum_mag  = cal_sum_q[SUM_W-1] ? (~sum_ext + 1'b1) : sum_ext;
  assign prod_mag = prod_q[PROD_W-1] ? (~prod_q + 1'b1) : prod_q;
  assign inc_mag  = div_quot_i[YAW_W-1:0];

  // Sequence one command at a time
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cal_sum_d   = cal_sum_q;
    bias_d      = bias_q;
    yaw_d       = yaw_q;
    ref_d       = ref_q;
    neg_d       = neg_q;
    diff_d      = diff_q;
    ticks_d     = ticks_q;
    prod_d      = prod_q;
    heading_d   = heading_q;
    out_valid_d = out_valid_q;
    cmd_pop_o   = 1'b0;
    div_req_o   = '0;

    // Drop the result once it has been taken
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      gyi_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          unique case (cmd_i.op)
            gyi_pkg::OP_CAL_SAMPLE: begin
              cal_sum_d = cal_sum_q + {{(SUM_W-SW){cmd_i.sample[SW-1]}}, cmd_i.sample};
              state_d   = gyi_pkg::ST_WRITE;
            end
            gyi_pkg::OP_ANGLE_RESET: begin
              ref_d   = yaw_q;
              state_d = gyi_pkg::ST_WRITE;
            end
            gyi_pkg::OP_END_CAL: begin
              neg_d           = cal_sum_q[SUM_W-1];
              div_req_o.start = 1'b1;
              div_req_o.sel   = gyi_pkg::DIV_CAL;
              div_req_o.num   = {{(NUM_W-SUM_W-8){1'b0}}, sum_mag[SUM_W-1:0], 8'h00}
                                + ROUND_CAL;
              state_d         = gyi_pkg::ST_DIVIDE;
            end
            gyi_pkg::OP_INTEGRATE: begin
              diff_d  = $signed({cmd_i.sample[SW-1], cmd_i.sample, 8'h00})
                        - $signed({bias_q[BW-1], bias_q});
              ticks_d = cmd_i.ticks;
              state_d = gyi_pkg::ST_MUL;
            end
            default: begin
              state_d = gyi_pkg::ST_IDLE;
            end
          endcase
        end
      end

      gyi_pkg::ST_MUL: begin
        prod_d  = diff_q * $signed({1'b0, ticks_q});
        state_d = gyi_pkg::ST_LOAD;
      end

      gyi_pkg::ST_LOAD: begin
        neg_d           = prod_q[PROD_W-1];
        div_req_o.start = 1'b1;
        div_req_o.sel   = gyi_pkg::DIV_TICK;
        div_req_o.num   = {prod_mag[NUM_W-9:0], 8'h00} + ROUND_TICK;
        state_d         = gyi_pkg::ST_DIVIDE;
      end

      gyi_pkg::ST_DIVIDE: begin
        if (div_done_i) begin
          if (op_q == gyi_pkg::OP_END_CAL) begin
            // Saturate the bias to its signed range
            if (!neg_q) begin
              bias_d = (div_quot_i > NUM_W'(gyi_pkg::BIAS_MAX)) ? gyi_pkg::BIAS_MAX
                                                                : div_quot_i[BW-1:0];
            end else begin
              bias_d = (div_quot_i > NUM_W'(gyi_pkg::BIAS_MIN)) ? gyi_pkg::BIAS_MIN
                                                                : (~div_quot_i[BW-1:0] + 1'b1);
            end
            cal_sum_d = '0;
            yaw_d     = '0;
            ref_d     = '0;
          end else begin
            yaw_d = neg_q ? (yaw_q - inc_mag) : (yaw_q + inc_mag);
          end
          state_d = gyi_pkg::ST_WRITE;
        end
      end

      gyi_pkg::ST_WRITE: begin
        if (!out_valid_q || pop) begin
          heading_d   = yaw_q - ref_q;
          out_valid_d = 1'b1;
          state_d     = gyi_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = gyi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gyi_pkg::ST_IDLE;
      op_q        <= gyi_pkg::OP_CAL_SAMPLE;
      cal_sum_q   <= '0;
      bias_q      <= '0;
      yaw_q       <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cal_sum_q   <= cal_sum_d;
      bias_q      <= bias_d;
      yaw_q       <= yaw_d;
      ref_q       <= ref_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working operands and the result word
  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    diff_q    <= diff_d;
    ticks_q   <= ticks_d;
    prod_q    <= prod_d;
    heading_q <= heading_d;
  end

  assign empty     = !out_valid_q;
  assign heading_o = heading_q;

endmodule

FILE: sv/gyro_yaw_integrator_unit.sv
// Gyro yaw integrator top level: front queue, back sequencer and shared divider.
// Takes one z-axis gyro word at a time through a queue-style push/full port and
// returns one heading word per input (yaw minus the angle-reset offset, degrees
// with 16 fraction bits, wrapping at 48 bits) through an empty/pop port. A
// two-word command queue sits between input and execution, and a one-word
// result register lets a new input be taken while a heading waits to be read.
// The back end serves one word at a time: calibration samples and angle resets
// go straight to the write state, end of calibration passes the divide state
// first, and integrate samples pass the multiply, load and divide states. Both
// divisions are by fixed divisors and run as a reciprocal multiplication split
// into four 25x25-bit partial products, one per cycle, and a registered done
// flag hands the quotient over; the multiply state forms the 25x17-bit
// rate-times-ticks product. Words wait in the queue while an earlier word is in
// service or a heading is left unread.
// CAL_SAMPLES (1..1024) is the fixed bias divisor; TICK_RATE (1..100000) is
// the number of ticks per second.
module gyro_yaw_integrator_unit #(
  parameter int unsigned CAL_SAMPLES = gyi_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned TICK_RATE   = gyi_pkg::TICK_RATE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            opcode_i,
  input  logic signed [gyi_pkg::SAMPLE_W-1:0]   rate_sample_i,
  input  logic [gyi_pkg::TICKS_W-1:0]           elapsed_ticks_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [gyi_pkg::HEADING_W-1:0]  heading_o
);

  logic                             cmd_valid;
  gyi_pkg::gyi_cmd_t                cmd;
  logic                             cmd_pop;
  gyi_pkg::gyi_div_req_t            div_req;
  logic                             div_done;
  logic [gyi_pkg::DIV_NUM_W-1:0]    div_quot;

  // Accept and classify input words
  gyi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .opcode_i        (opcode_i),
    .rate_sample_i   (rate_sample_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Execute commands and buffer the heading
  gyi_back #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .TICK_RATE   (TICK_RATE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .div_req_o   (div_req),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot),
    .pop         (pop),
    .empty       (empty),
    .heading_o   (heading_o)
  );

  // Shared constant divider
  gyi_divider #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .TICK_RATE   (TICK_RATE)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

endmodule

FILE: test/tb_gyro_yaw_integrator_unit.sv
// Self-checking testbench for the gyro yaw integrator: directed and random gyro words.
module tb_gyro_yaw_integrator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gyi_pkg::*;

  localparam int unsigned CAL_N       = CAL_SAMPLES_DEF;
  localparam int unsigned TICKS_PER_S = TICK_RATE_DEF;
  localparam longint      BIAS_HI     = 64'sd8388607;
  localparam longint      BIAS_LO     = -64'sd8388608;
  localparam int          RANDOM_WORDS = 1350;
  localparam int          SETTLE_CYCLES = 80;
  localparam int          CYCLE_LIMIT  = 4_000_000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  logic [1:0]                   opcode_i;
  logic signed [SAMPLE_W-1:0]   rate_sample_i;
  logic [TICKS_W-1:0]           elapsed_ticks_i;
  logic                         empty;
  logic                         pop;
  logic signed [HEADING_W-1:0]  heading_o;

  // Predicted block state
  logic signed [SUM_W-1:0]      cal_sum_p;
  logic signed [BIAS_W-1:0]     bias_p;
  logic [HEADING_W-1:0]         yaw_p;
  logic [HEADING_W-1:0]         yaw_ref_p;

  // Headings predicted but not yet read back
  logic [HEADING_W-1:0]         heading_q[$];

  int  words_sent;
  int  fail_cnt;
  int  cycle_cnt;
  bit  sender_calm;
  bit  recv_calm;

  gyro_yaw_integrator_unit #(
    .CAL_SAMPLES(CAL_N),
    .TICK_RATE  (TICKS_PER_S)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .rate_sample_i  (rate_sample_i),
    .elapsed_ticks_i(elapsed_ticks_i),
    .empty          (empty),
    .pop            (pop),
    .heading_o      (heading_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Divide rounding to nearest, ties away from zero
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Advance the predicted state by one word and return the heading it yields
  function automatic logic [HEADING_W-1:0] next_heading(gyi_op_e op,
                                                        logic signed [15:0] sample,
                                                        logic [15:0] ticks);
    longint b;
    longint diff;
    longint num;
    longint inc;
    longint t;
    t = ticks;
    case (op)
      OP_CAL_SAMPLE: begin
        cal_sum_p = cal_sum_p + sample;
      end
      OP_END_CAL: begin
        b = div_nearest(longint'(cal_sum_p) * 256, CAL_N);
        if (b > BIAS_HI) b = BIAS_HI;
        if (b < BIAS_LO) b = BIAS_LO;
        bias_p    = b[BIAS_W-1:0];
        cal_sum_p = '0;
        yaw_p     = '0;
        yaw_ref_p = '0;
      end
      OP_INTEGRATE: begin
        diff  = longint'(sample) * 256 - longint'(bias_p);
        num   = diff * t * 256;
        inc   = div_nearest(num, longint'(COUNTS_PER_DPS) * longint'(TICKS_PER_S));
        yaw_p = yaw_p + inc[HEADING_W-1:0];
      end
      default: begin
        yaw_ref_p = yaw_p;
      end
    endcase
    return yaw_p - yaw_ref_p;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic push_word(gyi_op_e op, logic [15:0] sample, logic [15:0] ticks);
    int gap;
    gap = sender_calm ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    opcode_i        <= op;
    rate_sample_i   <= sample;
    elapsed_ticks_i <= ticks;
    do @(posedge clk_i); while (full !== 1'b0);
    heading_q.push_back(next_heading(op, sample, ticks));
    words_sent++;
  endtask

  // Stop sending and wait until every predicted heading has been read
  task automatic drain_headings();
    push <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, every operation, zero ticks, samples outside calibration
  task automatic test_directed();
    push_word(OP_INTEGRATE, 16'sd1000, 16'd1000);
    push_word(OP_ANGLE_RESET, 16'h0000, 16'h0000);
    push_word(OP_INTEGRATE, 16'h8000, 16'hFFFF);
    push_word(OP_INTEGRATE, 16'h7FFF, 16'hFFFF);
    push_word(OP_INTEGRATE, 16'sd12345, 16'd0);
    // calibration samples arrive with no calibration under way
    push_word(OP_CAL_SAMPLE, 16'h7FFF, 16'hFFFF);
    push_word(OP_CAL_SAMPLE, 16'h8000, 16'h0000);
    push_word(OP_CAL_SAMPLE, 16'hFFFF, 16'h1234);
    push_word(OP_CAL_SAMPLE, 16'h0001, 16'h0000);
    push_word(OP_END_CAL, 16'hFFFF, 16'hFFFF);
    push_word(OP_INTEGRATE, 16'h0000, 16'd1);
    push_word(OP_INTEGRATE, 16'h0000, 16'hFFFF);
    push_word(OP_ANGLE_RESET, 16'hFFFF, 16'hFFFF);
    push_word(OP_INTEGRATE, -16'sd1000, 16'd5000);
    // hold the sender until the block has emptied
    drain_headings();
    push_word(OP_INTEGRATE, 16'sd200, 16'd30000);
    push_word(OP_ANGLE_RESET, 16'h0000, 16'h0000);
    push_word(OP_END_CAL, 16'h0000, 16'h0000);
    push_word(OP_INTEGRATE, 16'h7FFF, 16'hFFFF);
    push_word(OP_ANGLE_RESET, 16'h0000, 16'h0000);
    push_word(OP_INTEGRATE, 16'h8000, 16'hFFFF);
  endtask

  // Drive the bias into both saturation limits
  task automatic test_bias_saturation();
    repeat (CAL_N + 2) push_word(OP_CAL_SAMPLE, 16'h7FFF, 16'(16'($urandom)));
    push_word(OP_END_CAL, 16'h0000, 16'h0000);
    push_word(OP_INTEGRATE, 16'h8000, 16'hFFFF);
    push_word(OP_INTEGRATE, 16'h7FFF, 16'hFFFF);
    repeat (CAL_N + 2) push_word(OP_CAL_SAMPLE, 16'h8000, 16'(16'($urandom)));
    push_word(OP_END_CAL, 16'h0000, 16'h0000);
    push_word(OP_INTEGRATE, 16'h7FFF, 16'hFFFF);
    push_word(OP_INTEGRATE, 16'h8000, 16'hFFFF);
  endtask

  // Calibrate-then-integrate flights with random content, mixed with noise
  task automatic test_random_flights();
    int stop_at;
    int base;
    int n_cal;
    int n_int;
    int r;
    logic [15:0] ticks;
    logic [15:0] sample;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      sender_calm = ($urandom_range(0, 7) == 0);
      recv_calm   = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 7) begin
        base  = int'($urandom_range(0, 4000)) - 2000;
        n_cal = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                            : $urandom_range(CAL_N - 20, CAL_N + 20);
        repeat (n_cal) begin
          sample = 16'(base + int'($urandom_range(0, 200)) - 100);
          push_word(OP_CAL_SAMPLE, sample, 16'($urandom));
        end
        push_word(OP_END_CAL, 16'($urandom), 16'($urandom));
        n_int = $urandom_range(10, 60);
        repeat (n_int) begin
          r = $urandom_range(0, 19);
          if (r == 0) begin
            push_word(OP_ANGLE_RESET, 16'($urandom), 16'($urandom));
          end else begin
            sample = (r == 1) ? 16'($urandom)
                              : 16'(base + int'($urandom_range(0, 20000)) - 10000);
            case ($urandom_range(0, 9))
              0:       ticks = 16'd0;
              1, 2:    ticks = 16'($urandom);
              default: ticks = 16'($urandom_range(500, 1500));
            endcase
            push_word(OP_INTEGRATE, sample, ticks);
          end
        end
      end else begin
        repeat ($urandom_range(1, 20)) begin
          push_word(gyi_op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        end
      end
      if ($urandom_range(0, 15) == 0) drain_headings();
    end
    sender_calm = 1'b0;
    recv_calm   = 1'b0;
  endtask

  // Read headings back and compare them with the oldest prediction
  initial begin : heading_check
    logic [HEADING_W-1:0] want;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (pop && empty === 1'b0) begin
          if (heading_q.size() == 0) begin
            $error("heading: unexpected word, actual %0d", heading_o);
            fail_cnt++;
          end else begin
            want = heading_q.pop_front();
            if (heading_o !== want) begin
              $error("heading: expected %0d, actual %0d", $signed(want), heading_o);
              fail_cnt++;
            end
          end
        end
        if (hold > 0) begin
          pop <= 1'b0;
          hold--;
        end else begin
          pop <= 1'b1;
          hold = recv_calm ? 0 : idle_len();
        end
      end
    end
  end

  // Bound the run length
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_gyro_yaw_integrator_unit NOT OK");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    push            <= 1'b0;
    pop             <= 1'b0;
    opcode_i        <= OP_CAL_SAMPLE;
    rate_sample_i   <= '0;
    elapsed_ticks_i <= '0;
    cal_sum_p   = '0;
    bias_p      = '0;
    yaw_p       = '0;
    yaw_ref_p   = '0;
    words_sent  = 0;
    fail_cnt    = 0;
    sender_calm = 1'b0;
    recv_calm   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_bias_saturation();
    test_random_flights();

    // let the last headings arrive, then watch for strays
    drain_headings();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_gyro_yaw_integrator_unit OK");
    end else begin
      $display("tb_gyro_yaw_integrator_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: gyro_yaw_integrator_unit.f
sv/gyi_pkg.sv
sv/gyi_front.sv
sv/gyi_divider.sv
sv/gyi_back.sv
sv/gyro_yaw_integrator_unit.sv
test/tb_gyro_yaw_integrator_unit.sv
